[sv/sstf_pkg.sv]
// Package: shared types, constants and the control program of the state-space filter.
`default_nettype none

package sstf_pkg;

    localparam int MAX_ORDER = 3;
    localparam int ORDER_DEF = 3;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 24;
    localparam int DT_W     = 16;
    localparam int STATE_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // multiplier operands and accumulator
    localparam int OPA_W  = 25;
    localparam int OPB_W  = 33;
    localparam int ACC_W  = OPA_W + OPB_W;
    localparam int DIFF_W = 42;
    localparam int DLO_W  = 21;

    localparam int NUM_STEPS = 14;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEN0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEN1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEN2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DT   = 3'd7;

    localparam logic signed [COEF_W-1:0] GAIN_RST = 24'sd65536;
    localparam logic [DT_W-1:0]          DT_RST   = 16'd655;

    typedef enum logic [1:0] {A_GAIN, A_NUM, A_DEN, A_DT} t_asel;
    typedef enum logic [1:0] {B_X, B_STATE, B_DLO, B_DHI} t_bsel;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} t_accop;
    typedef enum logic [1:0] {SH_0, SH_16, SH_21} t_shift;
    typedef enum logic [2:0] {ACT_NONE, ACT_LOADX, ACT_OUT, ACT_DIFF, ACT_WRS} t_act;
    typedef enum logic [1:0] {COND_NONE, COND_NO_IN, COND_OUT_BUSY} t_cond;

    typedef struct packed {
        t_asel      asel;
        t_bsel      bsel;
        logic [1:0] midx;   // element for coefficient / state operand
        t_accop     accop;  // acts on the product of the previous step
        t_shift     shift;
        t_act       act;
        logic [1:0] widx;   // state element written by ACT_WRS
        t_cond      cond;   // true condition holds the step
        logic       last;
    } t_uword;

    typedef struct packed {
        t_uword w;
        logic   go;
    } t_ctrl;

    localparam t_uword UW_NOP = '{
        asel: A_GAIN, bsel: B_X, midx: 2'd0, accop: ACC_HOLD, shift: SH_0,
        act: ACT_NONE, widx: 2'd0, cond: COND_NONE, last: 1'b0
    };

    // Control program. Output dot product, then den dot product, diff,
    // and the state update from the highest element down so old values stay.
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = UW_NOP;
        case (step)
            STEP_W'(0): begin
                w.act  = ACT_LOADX;
                w.cond = COND_NO_IN;
            end
            STEP_W'(1): begin
                w.asel = A_GAIN; w.bsel = B_X;
            end
            STEP_W'(2): begin
                w.asel = A_NUM; w.bsel = B_STATE; w.midx = 2'd0;
                w.accop = ACC_LOAD; w.shift = SH_16;
            end
            STEP_W'(3): begin
                w.asel = A_NUM; w.bsel = B_STATE; w.midx = 2'd1; w.accop = ACC_ADD;
            end
            STEP_W'(4): begin
                w.asel = A_NUM; w.bsel = B_STATE; w.midx = 2'd2; w.accop = ACC_ADD;
            end
            STEP_W'(5): begin
                w.asel = A_DEN; w.bsel = B_STATE; w.midx = 2'd0; w.accop = ACC_ADD;
            end
            STEP_W'(6): begin
                w.asel = A_DEN; w.bsel = B_STATE; w.midx = 2'd1; w.accop = ACC_LOAD;
                w.act = ACT_OUT; w.cond = COND_OUT_BUSY;
            end
            STEP_W'(7): begin
                w.asel = A_DEN; w.bsel = B_STATE; w.midx = 2'd2; w.accop = ACC_ADD;
            end
            STEP_W'(8): begin
                w.asel = A_DT; w.bsel = B_STATE; w.midx = 2'd1; w.accop = ACC_ADD;
            end
            STEP_W'(9): begin
                w.asel = A_DT; w.bsel = B_STATE; w.midx = 2'd0; w.accop = ACC_LOAD;
                w.act = ACT_DIFF;
            end
            STEP_W'(10): begin
                w.asel = A_DT; w.bsel = B_DLO; w.accop = ACC_LOAD;
                w.act = ACT_WRS; w.widx = 2'd2;
            end
            STEP_W'(11): begin
                w.asel = A_DT; w.bsel = B_DHI; w.accop = ACC_LOAD;
                w.act = ACT_WRS; w.widx = 2'd1;
            end
            STEP_W'(12): begin
                w.accop = ACC_ADD; w.shift = SH_21;
            end
            STEP_W'(13): begin
                w.act = ACT_WRS; w.widx = 2'd0; w.last = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[sv/sstf_sequencer.sv]
// Step counter and control program fetch with hold conditions.
`default_nettype none

module sstf_sequencer (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire                 i_out_busy,
    output logic                o_stall,
    output sstf_pkg::t_ctrl     o_ctrl
);

    logic [sstf_pkg::STEP_W-1:0] r_step;
    logic [sstf_pkg::STEP_W-1:0] n_step;
    sstf_pkg::t_uword            w;
    logic                        hold;

    always_comb begin
        w = sstf_pkg::ucode(r_step);
        case (w.cond)
            sstf_pkg::COND_NO_IN:    hold = !i_valid;
            sstf_pkg::COND_OUT_BUSY: hold = i_out_busy;
            default:                 hold = 1'b0;
        endcase
    end

    always_comb begin
        if (hold) begin
            n_step = r_step;
        end else if (w.last) begin
            n_step = '0;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_stall   = (w.cond != sstf_pkg::COND_NO_IN);
    assign o_ctrl.w  = w;
    assign o_ctrl.go = !hold;

endmodule

`default_nettype wire

[sv/sstf_datapath.sv]
// Datapath: coefficient registers, state vector, shared multiplier, accumulator, output.
`default_nettype none

module sstf_datapath #(
    parameter int ORDER = sstf_pkg::ORDER_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  sstf_pkg::t_ctrl                       i_ctrl,
    input  wire                                   i_cfg_we,
    input  wire  [sstf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [sstf_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire  signed [sstf_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  wire                                   i_stall,
    output logic                                  o_valid,
    output logic signed [sstf_pkg::SAMPLE_W-1:0]  o_filtered_out,
    output logic                                  o_clipped,
    output logic                                  o_out_busy
);

    localparam int MO     = sstf_pkg::MAX_ORDER;
    localparam int ACC_W  = sstf_pkg::ACC_W;
    localparam int DIFF_W = sstf_pkg::DIFF_W;
    localparam int DLO_W  = sstf_pkg::DLO_W;
    localparam int SW     = sstf_pkg::STATE_W;
    localparam int XW     = sstf_pkg::SAMPLE_W;
    localparam int YW     = ACC_W + 1 - 32;
    localparam logic [2:0] ORD = 3'(ORDER);

    logic signed [sstf_pkg::COEF_W-1:0] r_num [MO];
    logic signed [sstf_pkg::COEF_W-1:0] r_den [MO];
    logic signed [sstf_pkg::COEF_W-1:0] r_gain;
    logic        [sstf_pkg::DT_W-1:0]   r_dt;
    logic signed [SW-1:0]               r_state [MO];
    logic signed [XW-1:0]               r_x;
    logic signed [DIFF_W-1:0]           r_diff;
    logic signed [ACC_W-1:0]            r_prod;
    logic signed [ACC_W-1:0]            r_acc;
    logic                               r_out_valid;
    logic signed [XW-1:0]               r_filt;
    logic                               r_clip;

    sstf_pkg::t_uword          w;
    logic                      go;
    logic                      m_ok;
    logic                      w_ok;
    logic [1:0]                midx;
    logic [1:0]                widx;
    logic signed [sstf_pkg::OPA_W-1:0] op_a;
    logic signed [sstf_pkg::OPB_W-1:0] op_b;
    logic signed [ACC_W-1:0]   mul_full;
    logic signed [ACC_W-1:0]   prod_sh;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W:0]     rnd;
    logic signed [YW-1:0]      y_full;
    logic signed [XW-1:0]      n_filt;
    logic                      n_clip;
    logic signed [DIFF_W-1:0]  n_diff;
    logic signed [SW+10:0]     upd_sum;
    logic signed [SW-1:0]      n_state;

    function automatic logic signed [SW-1:0] sat32(input logic signed [SW+10:0] v);
        logic signed [SW+10:0] hi;
        logic signed [SW+10:0] lo;
        hi = {{11{1'b0}}, 1'b0, {(SW-1){1'b1}}};
        lo = {{11{1'b1}}, 1'b1, {(SW-1){1'b0}}};
        if (v > hi) begin
            return {1'b0, {(SW-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(SW-1){1'b0}}};
        end else begin
            return v[SW-1:0];
        end
    endfunction

    assign w  = i_ctrl.w;
    assign go = i_ctrl.go;

    // elements at or above ORDER contribute zero and are never written
    assign m_ok = ({1'b0, w.midx} < ORD);
    assign w_ok = ({1'b0, w.widx} < ORD);
    assign midx = m_ok ? w.midx : 2'd0;
    assign widx = w_ok ? w.widx : 2'd0;

    always_comb begin
        case (w.asel)
            sstf_pkg::A_GAIN: op_a = {r_gain[sstf_pkg::COEF_W-1], r_gain};
            sstf_pkg::A_NUM:  op_a = {r_num[midx][sstf_pkg::COEF_W-1], r_num[midx]};
            sstf_pkg::A_DEN:  op_a = {r_den[midx][sstf_pkg::COEF_W-1], r_den[midx]};
            sstf_pkg::A_DT:   op_a = {9'b0, r_dt};
            default:          op_a = '0;
        endcase
        case (w.bsel)
            sstf_pkg::B_X:     op_b = {{(sstf_pkg::OPB_W-XW){r_x[XW-1]}}, r_x};
            sstf_pkg::B_STATE: op_b = {r_state[midx][SW-1], r_state[midx]};
            sstf_pkg::B_DLO:   op_b = {{(sstf_pkg::OPB_W-DLO_W){1'b0}}, r_diff[DLO_W-1:0]};
            sstf_pkg::B_DHI:   op_b = {{(sstf_pkg::OPB_W-DIFF_W+DLO_W){r_diff[DIFF_W-1]}},
                                       r_diff[DIFF_W-1:DLO_W]};
            default:           op_b = '0;
        endcase
    end

    always_comb begin
        if (!m_ok && (w.bsel == sstf_pkg::B_STATE ||
                      w.asel == sstf_pkg::A_NUM || w.asel == sstf_pkg::A_DEN)) begin
            mul_full = '0;
        end else begin
            mul_full = op_a * op_b;
        end
    end

    always_comb begin
        case (w.shift)
            sstf_pkg::SH_16: prod_sh = r_prod <<< 16;
            sstf_pkg::SH_21: prod_sh = r_prod <<< DLO_W;
            default:         prod_sh = r_prod;
        endcase
        case (w.accop)
            sstf_pkg::ACC_LOAD: n_acc = prod_sh;
            sstf_pkg::ACC_ADD:  n_acc = r_acc + prod_sh;
            default:            n_acc = r_acc;
        endcase
    end

    // round half up then floor by 2^32, saturate to 16 bits
    always_comb begin
        rnd    = {r_acc[ACC_W-1], r_acc} + ((ACC_W+1)'(1) <<< 31);
        y_full = rnd[ACC_W:32];
        if (y_full > YW'(32767)) begin
            n_filt = {1'b0, {(XW-1){1'b1}}};
            n_clip = 1'b1;
        end else if (y_full < -(YW'(32768))) begin
            n_filt = {1'b1, {(XW-1){1'b0}}};
            n_clip = 1'b1;
        end else begin
            n_filt = y_full[XW-1:0];
            n_clip = 1'b0;
        end
    end

    assign n_diff  = {{(DIFF_W-XW-16){r_x[XW-1]}}, r_x, 16'b0} - r_acc[ACC_W-1:16];
    assign upd_sum = {{11{r_state[widx][SW-1]}}, r_state[widx]}
                   + {r_acc[ACC_W-1], r_acc[ACC_W-1:16]};
    assign n_state = sat32(upd_sum);

    assign o_out_busy = r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MO; k++) begin
                r_num[k]   <= '0;
                r_den[k]   <= '0;
                r_state[k] <= '0;
            end
            r_gain      <= sstf_pkg::GAIN_RST;
            r_dt        <= sstf_pkg::DT_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sstf_pkg::REG_NUM0: r_num[0] <= i_cfg_data;
                    sstf_pkg::REG_NUM1: r_num[1] <= i_cfg_data;
                    sstf_pkg::REG_NUM2: r_num[2] <= i_cfg_data;
                    sstf_pkg::REG_DEN0: r_den[0] <= i_cfg_data;
                    sstf_pkg::REG_DEN1: r_den[1] <= i_cfg_data;
                    sstf_pkg::REG_DEN2: r_den[2] <= i_cfg_data;
                    sstf_pkg::REG_GAIN: r_gain   <= i_cfg_data;
                    sstf_pkg::REG_DT:   r_dt     <= i_cfg_data[sstf_pkg::DT_W-1:0];
                    default: ;
                endcase
            end
            if (go && w.act == sstf_pkg::ACT_WRS && w_ok) begin
                r_state[widx] <= n_state;
            end
            if (go && w.act == sstf_pkg::ACT_OUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_prod <= mul_full;
            r_acc  <= n_acc;
            if (w.act == sstf_pkg::ACT_LOADX) begin
                r_x <= i_sample_in;
            end
            if (w.act == sstf_pkg::ACT_DIFF) begin
                r_diff <= n_diff;
            end
            if (w.act == sstf_pkg::ACT_OUT) begin
                r_filt <= n_filt;
                r_clip <= n_clip;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_filtered_out = r_filt;
    assign o_clipped      = r_clip;

endmodule

`default_nettype wire

[sv/state_space_transfer_function.sv]
// Top level: state-space transfer function filter, controllable canonical form.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_sample_in
//   result    out        o_valid / i_stall    o_filtered_out, o_clipped
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// A 14-step control program drives one shared 25x33 multiplier and accumulator
// (output dot product, denominator dot product, then the Euler update). Reset is
// synchronous and restores the register defaults and a zero state. The next
// request is accepted while a result waits; a stalled result holds the program
// at its output step.
`default_nettype none

module state_space_transfer_function #(
    parameter int ORDER = sstf_pkg::ORDER_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire  signed [sstf_pkg::SAMPLE_W-1:0]  i_sample_in,
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic signed [sstf_pkg::SAMPLE_W-1:0]  o_filtered_out,
    output logic                                  o_clipped,
    input  wire                                   i_cfg_we,
    input  wire  [sstf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [sstf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    sstf_pkg::t_ctrl ctrl;
    logic            out_busy;

    sstf_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_busy (out_busy),
        .o_stall    (o_stall),
        .o_ctrl     (ctrl)
    );

    sstf_datapath #(
        .ORDER (ORDER)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_sample_in    (i_sample_in),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_filtered_out (o_filtered_out),
        .o_clipped      (o_clipped),
        .o_out_busy     (out_busy)
    );

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the state-space transfer function filter.
`timescale 1ns / 100ps

module testbench;

    localparam int SETTLE_CYCLES = 20;    // covers the state update after the last result
    localparam int IDLE_LIMIT    = 2000;  // cycles without any transfer before giving up
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 220;
    localparam int NUM_PHASES    = 8;

    localparam logic [sstf_pkg::CFG_DATA_W-1:0] Q16_ONE  = 24'h010000;
    localparam logic [sstf_pkg::CFG_DATA_W-1:0] Q16_HALF = 24'h008000;
    localparam logic [sstf_pkg::CFG_DATA_W-1:0] COEF_MAX = 24'h7FFFFF;
    localparam logic [sstf_pkg::CFG_DATA_W-1:0] COEF_MIN = 24'h800000;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind                              kind;
        logic [sstf_pkg::CFG_IDX_W-1:0]         idx;
        logic [sstf_pkg::CFG_DATA_W-1:0]        data;
        logic signed [sstf_pkg::SAMPLE_W-1:0]   x;
        logic                                   typed;  // expected result given in the row
        logic signed [sstf_pkg::SAMPLE_W-1:0]   ey;
        logic                                   ec;
    } t_stim_row;

    typedef struct packed {
        logic signed [sstf_pkg::SAMPLE_W-1:0] value;
        logic                                 clip;
    } t_filt_res;

    logic                                  i_clk = 1'b0;
    logic                                  r_rst_n = 1'b0;
    logic                                  r_valid = 1'b0;
    logic signed [sstf_pkg::SAMPLE_W-1:0]  r_sample = '0;
    logic                                  r_rx_stall = 1'b0;
    logic                                  r_we = 1'b0;
    logic [sstf_pkg::CFG_IDX_W-1:0]        r_idx = '0;
    logic [sstf_pkg::CFG_DATA_W-1:0]       r_data = '0;
    wire                                   o_stall;
    wire                                   o_valid;
    wire signed [sstf_pkg::SAMPLE_W-1:0]   o_filtered_out;
    wire                                   o_clipped;

    // filter model: coefficients, step and state vector
    longint num_c [sstf_pkg::MAX_ORDER];
    longint den_c [sstf_pkg::MAX_ORDER];
    longint gain_c;
    longint dt_c;
    longint st [sstf_pkg::MAX_ORDER];

    t_filt_res expected_out [$];
    t_stim_row stim_rows [$];
    int        mismatches = 0;
    int        results_got = 0;
    int        r_idle_cnt = 0;
    bit        settled = 1'b1;
    bit        no_gaps = 1'b0;

    state_space_transfer_function #(.ORDER(sstf_pkg::ORDER_DEF)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (r_rst_n),
        .i_valid        (r_valid),
        .o_stall        (o_stall),
        .i_sample_in    (r_sample),
        .o_valid        (o_valid),
        .i_stall        (r_rx_stall),
        .o_filtered_out (o_filtered_out),
        .o_clipped      (o_clipped),
        .i_cfg_we       (r_we),
        .i_cfg_idx      (r_idx),
        .i_cfg_data     (r_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // One filter step: output from the old state, then the Euler update.
    function automatic t_filt_res filter_step(input logic signed [sstf_pkg::SAMPLE_W-1:0] x);
        longint    xs;
        longint    acc;
        longint    y;
        longint    dsum;
        longint    diff;
        longint    prev [sstf_pkg::MAX_ORDER];
        t_filt_res r;
        xs = x;
        acc = gain_c * xs * 65536;
        dsum = 0;
        for (int i = 0; i < sstf_pkg::ORDER_DEF; i++) begin
            acc += num_c[i] * st[i];
            dsum += den_c[i] * st[i];
            prev[i] = st[i];
        end
        y = (acc + 64'sd2147483648) >>> 32;
        r.clip = 1'b0;
        if (y > 32767) begin
            y = 32767;
            r.clip = 1'b1;
        end else if (y < -32768) begin
            y = -32768;
            r.clip = 1'b1;
        end
        r.value = y[sstf_pkg::SAMPLE_W-1:0];
        diff = xs * 65536 - (dsum >>> 16);
        st[0] = sat32(prev[0] + ((dt_c * diff) >>> 16));
        for (int i = 1; i < sstf_pkg::ORDER_DEF; i++)
            st[i] = sat32(prev[i] + ((dt_c * prev[i-1]) >>> 16));
        return r;
    endfunction

    function automatic void add_write(input logic [sstf_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [sstf_pkg::CFG_DATA_W-1:0] data);
        stim_rows.push_back('{ROW_WRITE, idx, data, 16'sd0, 1'b0, 16'sd0, 1'b0});
    endfunction

    function automatic void add_sample(input logic signed [sstf_pkg::SAMPLE_W-1:0] x,
                                       input bit typed,
                                       input logic signed [sstf_pkg::SAMPLE_W-1:0] ey,
                                       input bit ec);
        stim_rows.push_back('{ROW_SAMPLE, '0, '0, x, typed, ey, ec});
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Register write, only with the block idle; the model takes it at the same edge.
    task automatic write_reg(input logic [sstf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sstf_pkg::CFG_DATA_W-1:0] data);
        r_valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        if (!settled) begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            settled = 1'b1;
        end
        r_we <= 1'b1;
        r_idx <= idx;
        r_data <= data;
        @(posedge i_clk);
        r_we <= 1'b0;
        case (idx)
            sstf_pkg::REG_NUM0: num_c[0] = signed'(data);
            sstf_pkg::REG_NUM1: num_c[1] = signed'(data);
            sstf_pkg::REG_NUM2: num_c[2] = signed'(data);
            sstf_pkg::REG_DEN0: den_c[0] = signed'(data);
            sstf_pkg::REG_DEN1: den_c[1] = signed'(data);
            sstf_pkg::REG_DEN2: den_c[2] = signed'(data);
            sstf_pkg::REG_GAIN: gain_c = signed'(data);
            sstf_pkg::REG_DT:   dt_c = data[sstf_pkg::DT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offers one request, records its expected result, then maybe idles a while.
    task automatic feed(input logic signed [sstf_pkg::SAMPLE_W-1:0] x, input bit typed,
                        input logic signed [sstf_pkg::SAMPLE_W-1:0] ey, input bit ec);
        t_filt_res p;
        int        r;
        int        gap;
        r_valid <= 1'b1;
        r_sample <= x;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        p = filter_step(x);
        if (typed) begin
            p.value = ey;
            p.clip = ec;
        end
        expected_out.push_back(p);
        settled = 1'b0;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else if (r < 98) gap = $urandom_range(4, 15);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            r_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_filt_res e;
        if (r_rst_n && o_valid === 1'b1 && !r_rx_stall) begin
            results_got++;
            if (expected_out.size() == 0) begin
                report_mismatch("unrequested result", o_filtered_out, 0);
            end else begin
                e = expected_out.pop_front();
                if (o_filtered_out !== e.value)
                    report_mismatch("filtered_out", o_filtered_out, e.value);
                if (o_clipped !== e.clip)
                    report_mismatch("clipped", o_clipped, e.clip);
            end
        end
    end

    // watchdog: counts cycles with no transfer on any port
    always @(posedge i_clk) begin
        if (!r_rst_n || r_we || (r_valid && o_stall === 1'b0) ||
            (o_valid === 1'b1 && !r_rx_stall))
            r_idle_cnt <= 0;
        else
            r_idle_cnt <= r_idle_cnt + 1;
        if (r_idle_cnt >= IDLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        int mode;
        int n;
        int hold_at;
        hold_at = 500;
        @(posedge i_clk);
        while (!r_rst_n) @(posedge i_clk);
        forever begin
            if (results_got >= hold_at) begin
                // long hold-off so the block fills up and stalls its input
                hold_at = (hold_at == 500) ? 1400 : 32'h7FFF_FFFF;
                r_rx_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 99);
                if (mode < 30) begin
                    r_rx_stall <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(posedge i_clk);
                end else if (mode < 90) begin
                    n = $urandom_range(1, 30);
                    repeat (n) begin
                        r_rx_stall <= ($urandom_range(0, 2) == 0);
                        @(posedge i_clk);
                    end
                end else begin
                    r_rx_stall <= 1'b1;
                    repeat ($urandom_range(10, 60)) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        logic [sstf_pkg::CFG_DATA_W-1:0]      vals [8];
        logic signed [sstf_pkg::SAMPLE_W-1:0] x;
        int                                   r;

        for (int i = 0; i < sstf_pkg::MAX_ORDER; i++) begin
            num_c[i] = 0;
            den_c[i] = 0;
            st[i] = 0;
        end
        gain_c = 65536;
        dt_c = 655;

        // defaults: unit feedthrough, zero numerator, so output equals input
        add_sample(16'sd0, 1, 16'sd0, 0);
        add_sample(16'sd32767, 1, 16'sd32767, 0);
        add_sample(-16'sd32768, 1, -16'sd32768, 0);
        add_sample(-16'sd1, 1, -16'sd1, 0);
        add_sample(16'sd1, 1, 16'sd1, 0);
        // gain extremes: output saturation both ways
        add_write(sstf_pkg::REG_GAIN, COEF_MAX);
        add_sample(16'sd32767, 1, 16'sd32767, 1);
        add_sample(-16'sd32768, 1, -16'sd32768, 1);
        add_sample(16'sd1, 1, 16'sd128, 0);
        add_write(sstf_pkg::REG_GAIN, COEF_MIN);
        add_sample(16'sd32767, 1, -16'sd32768, 1);
        add_sample(16'sd1, 1, -16'sd128, 0);
        // largest step drives the state into 32-bit saturation; output stays zero
        add_write(sstf_pkg::REG_GAIN, '0);
        add_write(sstf_pkg::REG_DT, 24'h00FFFF);
        add_sample(16'sd32767, 1, 16'sd0, 0);
        add_sample(16'sd32767, 1, 16'sd0, 0);
        add_sample(16'sd32767, 1, 16'sd0, 0);
        add_sample(-16'sd32768, 1, 16'sd0, 0);
        add_sample(-16'sd32768, 1, 16'sd0, 0);
        // coefficient extremes on a saturated state
        add_write(sstf_pkg::REG_NUM0, COEF_MAX);
        add_write(sstf_pkg::REG_NUM1, COEF_MIN);
        add_write(sstf_pkg::REG_NUM2, Q16_ONE);
        add_write(sstf_pkg::REG_DEN0, COEF_MAX);
        add_write(sstf_pkg::REG_DEN1, COEF_MIN);
        add_write(sstf_pkg::REG_DEN2, 24'h400000);
        add_sample(16'sd12345, 0, 16'sd0, 0);
        add_sample(-16'sd32768, 0, 16'sd0, 0);
        add_sample(16'sd32767, 0, 16'sd0, 0);
        add_sample(16'sd0, 0, 16'sd0, 0);
        add_sample(-16'sd1, 0, 16'sd0, 0);
        // zero step freezes the state
        add_write(sstf_pkg::REG_DT, '0);
        add_sample(16'sd100, 0, 16'sd0, 0);
        add_sample(-16'sd100, 0, 16'sd0, 0);

        repeat (6) @(posedge i_clk);
        r_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            if (stim_rows[k].kind == ROW_WRITE)
                write_reg(stim_rows[k].idx, stim_rows[k].data);
            else
                feed(stim_rows[k].x, stim_rows[k].typed, stim_rows[k].ey, stim_rows[k].ec);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int i = 0; i < 7; i++) begin
                case (ph)
                    0, 7:    vals[i] = '0;
                    1, 6:    vals[i] = 24'(int'($urandom_range(0, 131072)) - 65536);
                    3:       vals[i] = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
                    default: vals[i] = 24'($urandom);
                endcase
            end
            if (ph <= 1) begin
                // (s+1)^3 denominator: a well-damped low-pass
                vals[sstf_pkg::REG_DEN0] = 24'h030000;
                vals[sstf_pkg::REG_DEN1] = 24'h030000;
                vals[sstf_pkg::REG_DEN2] = Q16_ONE;
            end
            case (ph)
                0: begin
                    vals[sstf_pkg::REG_NUM2] = Q16_ONE;
                    vals[sstf_pkg::REG_DT] = 24'd655;
                end
                1: begin
                    vals[sstf_pkg::REG_GAIN] = Q16_HALF;
                    vals[sstf_pkg::REG_DT] = 24'd3277;
                end
                3:       vals[sstf_pkg::REG_DT] = 24'h00FFFF;
                4:       vals[sstf_pkg::REG_DT] = '0;
                6:       vals[sstf_pkg::REG_DT] = 24'($urandom_range(1, 1000));
                7: begin
                    vals[sstf_pkg::REG_GAIN] = Q16_ONE;
                    vals[sstf_pkg::REG_DT] = 24'(sstf_pkg::DT_RST);
                end
                default: vals[sstf_pkg::REG_DT] = 24'($urandom_range(0, 65535));
            endcase
            for (int i = 0; i < 8; i++)
                write_reg(sstf_pkg::CFG_IDX_W'(i), vals[i]);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    no_gaps = ($urandom_range(0, 2) == 0);
                if (ph == 2 && n == PHASE_ITEMS / 2) begin
                    // sender pauses until every result is back
                    r_valid <= 1'b0;
                    while (expected_out.size() != 0) @(posedge i_clk);
                end
                r = $urandom_range(0, 9);
                case (r)
                    0: begin
                        case ($urandom_range(0, 3))
                            0:       x = -16'sd32768;
                            1:       x = 16'sd32767;
                            2:       x = 16'sd0;
                            default: x = -16'sd1;
                        endcase
                    end
                    1, 2, 3: x = 16'(int'($urandom_range(0, 511)) - 256);
                    default: x = 16'($urandom);
                endcase
                feed(x, 0, 16'sd0, 0);
            end
        end

        r_valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
